### hdl/gbs_pkg.sv
// Shared types, constants and helpers of the greedy box suppression block.
package gbs_pkg;

  localparam int unsigned COORD_BITS   = 16;
  localparam int unsigned MAX_KEPT     = 64;
  localparam int unsigned CLASS_W      = 8;
  localparam int unsigned IDX_W        = 16;
  localparam int unsigned THR_W        = 16;
  localparam int unsigned CFG_W        = THR_W;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam int unsigned AREA_W  = 2 * COORD_BITS;
  localparam int unsigned UNION_W = AREA_W + 1;
  localparam int unsigned PROD_W  = UNION_W + THR_W;
  localparam int unsigned CNT_W   = $clog2(MAX_KEPT + 1);
  localparam int unsigned ADDR_W  = $clog2(MAX_KEPT);
  localparam int unsigned QP_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QF_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(29491);

  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_AGNOSTIC = CFG_IDX_W'(1);

  typedef struct packed {
    logic                         first_box;
    logic signed [COORD_BITS-1:0] left_edge;
    logic signed [COORD_BITS-1:0] top_edge;
    logic signed [COORD_BITS-1:0] right_edge;
    logic signed [COORD_BITS-1:0] bottom_edge;
    logic [CLASS_W-1:0]           class_label;
  } box_in_t;

  typedef struct packed {
    logic              keep;
    logic [IDX_W-1:0]  box_index;
    logic [CNT_W-1:0]  kept_total;
    logic              list_overflow;
  } result_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left_edge;
    logic signed [COORD_BITS-1:0] top_edge;
    logic signed [COORD_BITS-1:0] right_edge;
    logic signed [COORD_BITS-1:0] bottom_edge;
  } box_t;

  typedef struct packed {
    box_t               box;
    logic [CLASS_W-1:0] class_label;
    logic [AREA_W-1:0]  area;
  } kept_entry_t;

  typedef struct packed {
    logic             first_box;
    logic [IDX_W-1:0] box_index;
    kept_entry_t      ent;
  } queue_entry_t;

  typedef struct packed {
    logic hit_valid;
    logic hit;
    logic busy;
  } iou_status_t;

  function automatic logic [COORD_BITS-1:0] span_f(
    input logic signed [COORD_BITS-1:0] lo,
    input logic signed [COORD_BITS-1:0] hi
  );
    logic signed [COORD_BITS:0] diff;
    diff = $signed({hi[COORD_BITS-1], hi}) - $signed({lo[COORD_BITS-1], lo});
    return (hi > lo) ? diff[COORD_BITS-1:0] : '0;
  endfunction

endpackage

### hdl/gbs_front.sv
// Input stage: takes boxes, numbers them within the frame and computes their area.
module gbs_front import gbs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  box_in_t      in_data_i,
  output logic         in_stall_o,
  input  logic         q_full_i,
  output logic         q_push_o,
  output queue_entry_t q_data_o
);

  logic                  v_q;
  box_in_t               item_q;
  logic [COORD_BITS-1:0] w_q, h_q;
  logic [IDX_W-1:0]      idx_q, pos_q;
  logic [IDX_W-1:0]      idx_d;
  logic                  accept;

  assign in_stall_o = v_q & q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign q_push_o   = v_q & ~q_full_i;
  assign idx_d      = in_data_i.first_box ? '0 : pos_q;

  always_comb begin
    q_data_o                     = '0;
    q_data_o.first_box           = item_q.first_box;
    q_data_o.box_index           = idx_q;
    q_data_o.ent.box.left_edge   = item_q.left_edge;
    q_data_o.ent.box.top_edge    = item_q.top_edge;
    q_data_o.ent.box.right_edge  = item_q.right_edge;
    q_data_o.ent.box.bottom_edge = item_q.bottom_edge;
    q_data_o.ent.class_label     = item_q.class_label;
    q_data_o.ent.area            = AREA_W'(w_q) * AREA_W'(h_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      pos_q <= '0;
    end else if (accept) begin
      v_q    <= 1'b1;
      item_q <= in_data_i;
      w_q    <= span_f(in_data_i.left_edge, in_data_i.right_edge);
      h_q    <= span_f(in_data_i.top_edge, in_data_i.bottom_edge);
      idx_q  <= idx_d;
      pos_q  <= idx_d + 1'b1;
    end else if (q_push_o) begin
      v_q <= 1'b0;
    end
  end

endmodule

### hdl/gbs_queue.sv
// Short queue between the input stage and the suppression sequencer.
module gbs_queue import gbs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  queue_entry_t push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output queue_entry_t pop_data_o,
  output logic         empty_o
);

  queue_entry_t     slots_q [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QF_W-1:0]  fill_q;
  logic             do_push, do_pop;

  assign full_o     = fill_q == QF_W'(QUEUE_DEPTH);
  assign empty_o    = fill_q == '0;
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = slots_q[rd_ptr_q];

  function automatic logic [QP_W-1:0] next_ptr(input logic [QP_W-1:0] p);
    return (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) fill_q <= fill_q + 1'b1;
      else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
    end
  end

endmodule

### hdl/gbs_iou.sv
// Pipelined overlap test of the current box against one stored box per cycle.
module gbs_iou import gbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  kept_entry_t       kept_i,
  input  kept_entry_t       cur_i,
  input  logic [THR_W-1:0]  thr_i,
  input  logic              agnostic_i,
  output iou_status_t       status_o
);

  logic signed [COORD_BITS-1:0] ix0, iy0, ix1, iy1;

  logic                  va_q, vb_q, vc_q, vd_q, hit_v_q, hit_q;
  logic                  ma_q, mb_q, mc_q, md_q;
  logic [COORD_BITS-1:0] iw_q, ih_q;
  logic [AREA_W-1:0]     karea_a_q, karea_b_q, inter_b_q, inter_c_q, inter_d_q;
  logic [UNION_W-1:0]    uni_c_q;
  logic [PROD_W-1:0]     prod_d_q;

  always_comb begin
    ix0 = (cur_i.box.left_edge > kept_i.box.left_edge) ?
          cur_i.box.left_edge : kept_i.box.left_edge;
    iy0 = (cur_i.box.top_edge > kept_i.box.top_edge) ?
          cur_i.box.top_edge : kept_i.box.top_edge;
    ix1 = (cur_i.box.right_edge < kept_i.box.right_edge) ?
          cur_i.box.right_edge : kept_i.box.right_edge;
    iy1 = (cur_i.box.bottom_edge < kept_i.box.bottom_edge) ?
          cur_i.box.bottom_edge : kept_i.box.bottom_edge;
  end

  always_ff @(posedge clk_i) begin
    iw_q      <= span_f(ix0, ix1);
    ih_q      <= span_f(iy0, iy1);
    karea_a_q <= kept_i.area;
    ma_q      <= agnostic_i | (kept_i.class_label == cur_i.class_label);

    inter_b_q <= AREA_W'(iw_q) * AREA_W'(ih_q);
    karea_b_q <= karea_a_q;
    mb_q      <= ma_q;

    uni_c_q   <= UNION_W'(cur_i.area) + UNION_W'(karea_b_q) - UNION_W'(inter_b_q);
    inter_c_q <= inter_b_q;
    mc_q      <= mb_q;

    prod_d_q  <= PROD_W'(thr_i) * PROD_W'(uni_c_q);
    inter_d_q <= inter_c_q;
    md_q      <= mc_q;

    hit_q     <= md_q & ({PROD_W'(inter_d_q), THR_W'(0)} > {THR_W'(0), prod_d_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vc_q    <= 1'b0;
      vd_q    <= 1'b0;
      hit_v_q <= 1'b0;
    end else begin
      va_q    <= valid_i;
      vb_q    <= va_q;
      vc_q    <= vb_q;
      vd_q    <= vc_q;
      hit_v_q <= vd_q;
    end
  end

  assign status_o.hit_valid = hit_v_q;
  assign status_o.hit       = hit_q;
  assign status_o.busy      = va_q | vb_q | vc_q | vd_q | hit_v_q;

endmodule

### hdl/gbs_back.sv
// Suppression sequencer: scans the kept list, decides, stores survivors, reports.
module gbs_back import gbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  queue_entry_t     q_data_i,
  output logic             q_pop_o,
  input  logic [THR_W-1:0] thr_i,
  input  logic             agnostic_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output result_t          out_data_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q, addr_q;
  logic             suppress_q;
  kept_entry_t      cur_q;
  logic [IDX_W-1:0] idx_q;
  logic             rd_v_q;
  kept_entry_t      rd_data_q;
  kept_entry_t      mem_q [MAX_KEPT];
  result_t          out_q;
  logic             out_valid_q;
  iou_status_t      iou_st;
  logic             issue, in_flight, can_emit, room, keep, finish;

  assign issue     = (state_q == ST_SCAN) && (addr_q < count_q);
  assign in_flight = rd_v_q | iou_st.busy;
  assign can_emit  = ~out_valid_q | ~out_stall_i;
  assign room      = count_q < CNT_W'(MAX_KEPT);
  assign keep      = ~suppress_q;
  assign finish    = (state_q == ST_FINISH) && can_emit;
  assign q_pop_o   = (state_q == ST_IDLE) && !q_empty_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  gbs_iou u_iou (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (rd_v_q),
    .kept_i     (rd_data_q),
    .cur_i      (cur_q),
    .thr_i      (thr_i),
    .agnostic_i (agnostic_i),
    .status_o   (iou_st)
  );

  always_ff @(posedge clk_i) begin
    if (issue) rd_data_q <= mem_q[addr_q[ADDR_W-1:0]];
    if (finish && keep && room) mem_q[count_q[ADDR_W-1:0]] <= cur_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      addr_q      <= '0;
      suppress_q  <= 1'b0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_v_q <= issue;
      if (finish) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            cur_q      <= q_data_i.ent;
            idx_q      <= q_data_i.box_index;
            addr_q     <= '0;
            suppress_q <= 1'b0;
            if (q_data_i.first_box) count_q <= '0;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) addr_q <= addr_q + 1'b1;
          if (iou_st.hit_valid && iou_st.hit) suppress_q <= 1'b1;
          if (!issue && !in_flight) state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (can_emit) begin
            out_q.keep          <= keep;
            out_q.box_index     <= idx_q;
            out_q.list_overflow <= keep & ~room;
            out_q.kept_total    <= (keep && room) ? count_q + 1'b1 : count_q;
            if (keep && room) count_q <= count_q + 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_KEPT))
    else $error("kept count beyond capacity");

  a_finish_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |-> !rd_v_q && !iou_st.busy)
    else $error("decision taken with compares in flight");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.list_overflow |-> out_q.keep && out_q.kept_total == CNT_W'(MAX_KEPT))
    else $error("overflow reported while store not full");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish && keep && room |=> count_q == $past(count_q) + 1'b1)
    else $error("stored box not counted");

endmodule

### hdl/greedy_box_suppression.sv
// Greedy box suppression: top level with configuration registers.
// Boxes arrive sorted by descending score and each yields one result transfer. A box is
// compared with every box stored for the frame through one pipelined overlap unit, one
// stored box per cycle, while the sequencer scans the kept list. The input stage and a
// two-entry queue keep taking boxes while the sequencer works and while a result waits to
// be taken, until the queue is full. Write configuration only while the block is idle.
module greedy_box_suppression import gbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  box_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output result_t              out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic [THR_W-1:0] thr_q;
  logic             agnostic_q;
  logic             q_push, q_full, q_pop, q_empty;
  queue_entry_t     q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= THR_RESET;
      agnostic_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IOU_THRESHOLD:  thr_q      <= cfg_wdata_i[THR_W-1:0];
        CFG_CLASS_AGNOSTIC: agnostic_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  gbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  gbs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_out),
    .empty_o     (q_empty)
  );

  gbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .thr_i       (thr_q),
    .agnostic_i  (agnostic_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
